### design/key_slot_range_router_top_defines.svh
// Assertion macros for the key slot range router.
// Used by key_slot_range_router_top; expects i_clk and i_rst_n in scope.
`ifndef KEY_SLOT_RANGE_ROUTER_TOP_DEFINES_SVH
`define KEY_SLOT_RANGE_ROUTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KSRR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("router assertion failed");
// next-cycle implication
`define KSRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("router assertion failed");
`else
`define KSRR_ASSERT_NOW(lbl, ante, cons)
`define KSRR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### design/ksrr_pkg.sv
// Shared types, codes and CRC helpers for the key slot range router.
// No dependencies.
package ksrr_pkg;

    localparam int SLOT_W  = 14;
    localparam int NODE_W  = 8;
    localparam int CNT_W   = 7;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] MODE_KEY    = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DROP   = 2'd2;

    localparam logic [2:0] STS_ROUTED   = 3'd0;
    localparam logic [2:0] STS_UNMAPPED = 3'd1;
    localparam logic [2:0] STS_INSERTED = 3'd2;
    localparam logic [2:0] STS_OVERLAP  = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;
    localparam logic [2:0] STS_BADRANGE = 3'd5;
    localparam logic [2:0] STS_DROPPED  = 3'd6;

    localparam logic REG_CLUSTER = 1'b0;
    localparam logic REG_HOME    = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DROP   = 2'd2
    } t_op;

    // request walking down the cell chain
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [SLOT_W-1:0] lo;      // slot for a lookup
        logic [SLOT_W-1:0] hi;
        logic [NODE_W-1:0] node;
        logic              hit;
        logic [NODE_W-1:0] owner;
        logic              overlap;
        logic              free_found;
        logic [CNT_W-1:0]  count;
    } t_tok;

    // entry write from the top
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] lo;
        logic [SLOT_W-1:0] hi;
        logic [NODE_W-1:0] owner;
    } t_wr;

    // one byte of CRC-16/XMODEM, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    localparam logic [15:0] PREFIX_SEED =
        crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(crc_byte(
            16'h0000, "c"), "h"), "a"), "n"), "n"), "e"), "l"), ":");

endpackage

### design/key_slot_range_router_top.sv
// Top level of the key slot range router: CRC, APB registers, control and
// the chain of table cells. Depends on ksrr_pkg, ksrr_cell and the defines header.
`include "key_slot_range_router_top_defines.svh"

// A key byte that is not the last one gives no result and leaves busy low.
// The last byte of a key with clustering off, and an insert with a bad range,
// give their result in the cycle after start. A lookup, an insert or a drop
// walks the request through the row of TABLE_ENTRIES cells, one cell per
// cycle, the result is registered once it leaves the last cell, and busy
// stays high until then. o_valid marks each result for one cycle; the
// receiver cannot stall it. No clearing pass is needed after reset.
module key_slot_range_router_top import ksrr_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_key_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    input  logic              i_channel_prefix,
    input  logic [13:0]       i_range_low,
    input  logic [13:0]       i_range_high,
    input  logic [7:0]        i_node_id,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [13:0]       o_slot,
    output logic [7:0]        o_target_node,
    output logic [6:0]        o_dropped_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state            r_state;
    logic [15:0]       r_crc;
    logic              r_cluster;
    logic [7:0]        r_home;
    t_tok              r_tok;
    logic              r_valid;
    logic [2:0]        r_status;
    logic [13:0]       r_slot;
    logic [7:0]        r_target;
    logic [6:0]        r_count;
    logic              w_accept;
    logic              w_bad_range;
    logic [15:0]       w_crc;
    t_tok              w_tok [0:TABLE_ENTRIES];
    logic [IX_W-1:0]   w_ix  [0:TABLE_ENTRIES];
    t_tok              w_tail;
    t_wr               w_wr;

    // registers, writes and reads
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HOME) ? {24'h0, r_home} : {31'h0, r_cluster};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster <= 1'b0;
            r_home    <= 8'h00;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_CLUSTER) r_cluster <= pwdata[0];
            else                         r_home    <= pwdata[7:0];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_bad_range = w_accept && (i_mode == MODE_INSERT) && (i_range_low > i_range_high);
    assign w_crc    = crc_byte(i_first_byte ? (i_channel_prefix ? PREFIX_SEED : 16'h0000)
                                            : r_crc, i_key_byte);

    // cell chain
    assign w_tok[0] = r_tok;
    assign w_ix[0]  = '0;
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ksrr_cell #(.IDX(g), .IX_W(IX_W)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok[g]),
            .i_free_ix (w_ix[g]),
            .i_wr      (w_wr),
            .i_wr_ix   (w_ix[TABLE_ENTRIES]),
            .o_tok     (w_tok[g+1]),
            .o_free_ix (w_ix[g+1])
        );
    end
    assign w_tail = w_tok[TABLE_ENTRIES];

    // write the new range once the walk found no overlap and a free entry
    assign w_wr.en    = w_tail.valid && (w_tail.op == OP_INSERT) && !w_tail.overlap
                        && w_tail.free_found;
    assign w_wr.lo    = w_tail.lo;
    assign w_wr.hi    = w_tail.hi;
    assign w_wr.owner = w_tail.node;

    // launch requests, finish walks, drive results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_crc   <= 16'h0000;
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
            r_status    <= STS_ROUTED;
            r_slot      <= '0;
            r_target    <= '0;
            r_count     <= '0;
            if (w_accept) begin
                r_tok.lo         <= i_range_low;
                r_tok.hi         <= i_range_high;
                r_tok.node       <= i_node_id;
                r_tok.hit        <= 1'b0;
                r_tok.owner      <= '0;
                r_tok.overlap    <= 1'b0;
                r_tok.free_found <= 1'b0;
                r_tok.count      <= '0;
                case (i_mode)
                    MODE_KEY: begin
                        r_crc <= w_crc;
                        if (i_last_byte) begin
                            if (!r_cluster) begin
                                r_valid  <= 1'b1;
                                r_slot   <= w_crc[13:0];
                                r_target <= r_home;
                            end else begin
                                r_tok.valid <= 1'b1;
                                r_tok.op    <= OP_LOOKUP;
                                r_tok.lo    <= w_crc[13:0];
                                r_state     <= S_WALK;
                            end
                        end
                    end
                    MODE_INSERT: begin
                        if (i_range_low > i_range_high) begin
                            r_valid  <= 1'b1;
                            r_status <= STS_BADRANGE;
                        end else begin
                            r_tok.valid <= 1'b1;
                            r_tok.op    <= OP_INSERT;
                            r_state     <= S_WALK;
                        end
                    end
                    MODE_DROP: begin
                        r_tok.valid <= 1'b1;
                        r_tok.op    <= OP_DROP;
                        r_state     <= S_WALK;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end else if (w_tail.valid) begin
                r_valid <= 1'b1;
                r_state <= S_IDLE;
                case (w_tail.op)
                    OP_LOOKUP: begin
                        r_slot <= w_tail.lo;
                        if (w_tail.hit) begin
                            r_target <= w_tail.owner;
                        end else begin
                            r_status <= STS_UNMAPPED;
                        end
                    end
                    OP_INSERT: begin
                        if (w_tail.overlap)         r_status <= STS_OVERLAP;
                        else if (w_tail.free_found) r_status <= STS_INSERTED;
                        else                        r_status <= STS_FULL;
                    end
                    OP_DROP: begin
                        r_status <= STS_DROPPED;
                        r_count  <= w_tail.count;
                    end
                    default: r_status <= STS_ROUTED;
                endcase
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_target_node   = r_target;
    assign o_dropped_count = r_count;

    `KSRR_ASSERT_NOW(a_tail_in_walk, w_tail.valid, r_state == S_WALK)
    `KSRR_ASSERT_NEXT(a_mid_key_quiet, w_accept && i_mode == MODE_KEY && !i_last_byte, !o_valid)
    `KSRR_ASSERT_NEXT(a_bad_range, w_bad_range, o_valid && o_status == STS_BADRANGE)
    `KSRR_ASSERT_NEXT(a_walk_ends, w_tail.valid, o_valid && !busy)
    `KSRR_ASSERT_NOW(a_no_launch_busy, busy, !w_accept)

endmodule

### design/ksrr_cell.sv
// One table entry of the router chain: holds a range and its owner and
// updates the passing request. Depends on ksrr_pkg.
module ksrr_cell import ksrr_pkg::*; #(
    parameter int IDX  = 0,
    parameter int IX_W = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_tok            i_tok,
    input  logic [IX_W-1:0] i_free_ix,
    input  t_wr             i_wr,
    input  logic [IX_W-1:0] i_wr_ix,
    output t_tok            o_tok,
    output logic [IX_W-1:0] o_free_ix
);

    logic              r_valid;
    logic [SLOT_W-1:0] r_lo;
    logic [SLOT_W-1:0] r_hi;
    logic [NODE_W-1:0] r_owner;
    t_tok              r_tok;
    logic [IX_W-1:0]   r_free_ix;
    t_tok              n_tok;
    logic [IX_W-1:0]   n_free_ix;
    logic              w_drop;
    logic              w_mine;

    assign w_mine = i_wr.en && (i_wr_ix == IX_W'(IDX));
    assign w_drop = i_tok.valid && (i_tok.op == OP_DROP) && r_valid && (r_owner == i_tok.node);

    // update the request with this entry
    always_comb begin
        n_tok     = i_tok;
        n_free_ix = i_free_ix;
        case (i_tok.op)
            OP_LOOKUP: begin
                if (!i_tok.hit && r_valid && r_lo <= i_tok.lo && r_hi >= i_tok.lo) begin
                    n_tok.hit   = 1'b1;
                    n_tok.owner = r_owner;
                end
            end
            OP_INSERT: begin
                if (r_valid) begin
                    if (!(r_hi < i_tok.lo || r_lo > i_tok.hi)) n_tok.overlap = 1'b1;
                end else if (!i_tok.free_found) begin
                    n_tok.free_found = 1'b1;
                    n_free_ix        = IX_W'(IDX);
                end
            end
            OP_DROP: begin
                if (w_drop && i_tok.count != {CNT_W{1'b1}}) n_tok.count = i_tok.count + 1'b1;
            end
            default: n_tok = i_tok;
        endcase
    end

    // hold the entry; write on insert, clear on drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_mine) begin
            r_valid <= 1'b1;
        end else if (w_drop) begin
            r_valid <= 1'b0;
        end
        if (w_mine) begin
            r_lo    <= i_wr.lo;
            r_hi    <= i_wr.hi;
            r_owner <= i_wr.owner;
        end
    end

    // advance the request to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.op         <= n_tok.op;
        r_tok.lo         <= n_tok.lo;
        r_tok.hi         <= n_tok.hi;
        r_tok.node       <= n_tok.node;
        r_tok.hit        <= n_tok.hit;
        r_tok.owner      <= n_tok.owner;
        r_tok.overlap    <= n_tok.overlap;
        r_tok.free_found <= n_tok.free_found;
        r_tok.count      <= n_tok.count;
        r_free_ix        <= n_free_ix;
    end

    assign o_tok     = r_tok;
    assign o_free_ix = r_free_ix;

endmodule
